// ===== rtl/core/descriptor_best_two_matcher_defines.svh =====
// Assertion macros for the descriptor best-two matcher.
// Used by the top level; the assertions expect signals clk and rst_n in scope.
`ifndef DESCRIPTOR_BEST_TWO_MATCHER_DEFINES_SVH
`define DESCRIPTOR_BEST_TWO_MATCHER_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked outside reset.
`define DBTM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define DBTM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DBTM_ASSERT(lbl, prop, msg)
`define DBTM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/core/dbtm_pkg.sv =====
// Shared constants, codes and types of the descriptor best-two matcher.
// No dependencies; every module of the block imports this package.
package dbtm_pkg;

  localparam int DESC_BYTES = 32;
  localparam int INDEX_BITS = 16;

  localparam int WORD_W     = 64;
  localparam int NUM_WORDS  = 4;
  localparam int LANE_BYTES = 8;
  localparam int NUM_LANES  = (DESC_BYTES + LANE_BYTES - 1) / LANE_BYTES;
  localparam int PORT_IDX_W = 16;
  localparam int IDX_W      = (INDEX_BITS < PORT_IDX_W) ? INDEX_BITS : PORT_IDX_W;
  // Eight squared byte differences reach 520200 at most.
  localparam int LANE_W     = 20;
  // Thirty-two squared byte differences reach 2080800 at most.
  localparam int DIST_W     = 21;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic CMD_START     = 1'b0;
  localparam logic CMD_CANDIDATE = 1'b1;

  localparam logic MODE_HAMMING = 1'b0;
  localparam logic MODE_L2      = 1'b1;

  localparam logic REG_DISTANCE_MODE = 1'b0;

  typedef struct packed {
    logic              cmd;
    logic              last;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] distance;
  } dbtm_item_t;

  typedef struct packed {
    logic [PORT_IDX_W-1:0] query_index;
    logic [PORT_IDX_W-1:0] best_index;
    logic [DIST_W-1:0]     best_distance;
    logic [PORT_IDX_W-1:0] second_index;
    logic [DIST_W-1:0]     second_distance;
  } dbtm_result_t;

  // Bytes of a lane that fall inside the descriptor length.
  function automatic logic [LANE_BYTES-1:0] lane_mask(input int lane);
    logic [LANE_BYTES-1:0] m;
    for (int b = 0; b < LANE_BYTES; b++) begin
      m[b] = ((lane * LANE_BYTES + b) < DESC_BYTES);
    end
    return m;
  endfunction

endpackage

// ===== rtl/core/dbtm_lane.sv =====
// One distance lane: Hamming or squared L2 partial over eight descriptor bytes.
// Depends on dbtm_pkg.
module dbtm_lane
  import dbtm_pkg::*;
(
  input  logic                  mode,
  input  logic [WORD_W-1:0]     query_word,
  input  logic [WORD_W-1:0]     cand_word,
  input  logic [LANE_BYTES-1:0] byte_mask,
  output logic [LANE_W-1:0]     partial
);

  localparam int HAM_W = 7;

  logic [7:0]        q_b;
  logic [7:0]        c_b;
  logic [7:0]        x_b;
  logic [7:0]        d_b;
  logic [15:0]       sq_b;
  logic [3:0]        pop_b;
  logic [LANE_W-1:0] sq_sum;
  logic [HAM_W-1:0]  ham_sum;

  always_comb begin
    q_b     = '0;
    c_b     = '0;
    x_b     = '0;
    d_b     = '0;
    sq_b    = '0;
    pop_b   = '0;
    sq_sum  = '0;
    ham_sum = '0;
    for (int b = 0; b < LANE_BYTES; b++) begin
      q_b  = query_word[8*b +: 8];
      c_b  = cand_word[8*b +: 8];
      x_b  = q_b ^ c_b;
      d_b  = (q_b > c_b) ? (q_b - c_b) : (c_b - q_b);
      sq_b = 16'(d_b) * 16'(d_b);
      pop_b = '0;
      for (int k = 0; k < 8; k++) begin
        pop_b = pop_b + 4'(x_b[k]);
      end
      if (byte_mask[b]) begin
        sq_sum  = sq_sum + LANE_W'(sq_b);
        ham_sum = ham_sum + HAM_W'(pop_b);
      end
    end
    partial = (mode == MODE_L2) ? sq_sum : LANE_W'(ham_sum);
  end

endmodule

// ===== rtl/core/dbtm_merge.sv =====
// Merging stage: adds the lane partials into the full descriptor distance.
// Depends on dbtm_pkg.
module dbtm_merge
  import dbtm_pkg::*;
(
  input  logic [LANE_W-1:0] partial [NUM_LANES],
  output logic [DIST_W-1:0] total
);

  always_comb begin
    total = '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      total = total + DIST_W'(partial[l]);
    end
  end

endmodule

// ===== rtl/core/dbtm_tracker.sv =====
// Best-two tracker: keeps the two nearest candidates of a run and holds the
// result word until it is taken. Depends on dbtm_pkg.
module dbtm_tracker
  import dbtm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  dbtm_item_t   item,
  input  logic         item_valid,
  output logic         item_take,
  input  logic         out_ready,
  output logic         out_valid,
  output dbtm_result_t result
);

  logic [1:0]        count_r, count_nxt;
  logic [IDX_W-1:0]  cur_query_r, cur_query_nxt;
  logic [DIST_W-1:0] first_dist_r, first_dist_nxt;
  logic [IDX_W-1:0]  first_idx_r, first_idx_nxt;
  logic [DIST_W-1:0] runner_dist_r, runner_dist_nxt;
  logic [IDX_W-1:0]  runner_idx_r, runner_idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  dbtm_result_t      result_r, result_nxt;
  logic              emit;

  // A last candidate emits only when the run already holds at least one candidate.
  assign emit      = (item.cmd == CMD_CANDIDATE) && item.last && (count_r != 2'd0);
  assign item_take = item_valid && (!emit || !out_valid_r || out_ready);

  always_comb begin
    count_nxt       = count_r;
    cur_query_nxt   = cur_query_r;
    first_dist_nxt  = first_dist_r;
    first_idx_nxt   = first_idx_r;
    runner_dist_nxt = runner_dist_r;
    runner_idx_nxt  = runner_idx_r;
    if (item.cmd == CMD_START) begin
      cur_query_nxt = item.idx;
      count_nxt     = 2'd0;
    end else begin
      case (count_r)
        2'd0: begin
          first_dist_nxt = item.distance;
          first_idx_nxt  = item.idx;
          count_nxt      = 2'd1;
        end
        2'd1: begin
          // On a tie the newer candidate takes the best place.
          if (first_dist_r < item.distance) begin
            runner_dist_nxt = item.distance;
            runner_idx_nxt  = item.idx;
          end else begin
            runner_dist_nxt = first_dist_r;
            runner_idx_nxt  = first_idx_r;
            first_dist_nxt  = item.distance;
            first_idx_nxt   = item.idx;
          end
          count_nxt = 2'd2;
        end
        default: begin
          if (item.distance < first_dist_r) begin
            runner_dist_nxt = first_dist_r;
            runner_idx_nxt  = first_idx_r;
            first_dist_nxt  = item.distance;
            first_idx_nxt   = item.idx;
          end else if (item.distance < runner_dist_r) begin
            runner_dist_nxt = item.distance;
            runner_idx_nxt  = item.idx;
          end
          count_nxt = 2'd2;
        end
      endcase
      if (item.last) begin
        count_nxt = 2'd0;
      end
    end

    result_nxt = '{query_index:     PORT_IDX_W'(cur_query_r),
                   best_index:      PORT_IDX_W'(first_idx_nxt),
                   best_distance:   first_dist_nxt,
                   second_index:    PORT_IDX_W'(runner_idx_nxt),
                   second_distance: runner_dist_nxt};

    if (item_take && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r       <= 2'd0;
      cur_query_r   <= '0;
      first_dist_r  <= '0;
      first_idx_r   <= '0;
      runner_dist_r <= '0;
      runner_idx_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (item_take) begin
        count_r       <= count_nxt;
        cur_query_r   <= cur_query_nxt;
        first_dist_r  <= first_dist_nxt;
        first_idx_r   <= first_idx_nxt;
        runner_dist_r <= runner_dist_nxt;
        runner_idx_r  <= runner_idx_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && emit) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

endmodule

// ===== rtl/core/descriptor_best_two_matcher.sv =====
// Top level of the descriptor best-two matcher: input pipeline, distance lanes,
// merge, tracker and the configuration register. Depends on dbtm_pkg, dbtm_lane,
// dbtm_merge, dbtm_tracker and descriptor_best_two_matcher_defines.svh.
//
// The block takes one word per clock, start or candidate, while the output is
// not backed up. Four lanes of eight bytes each measure a candidate against the
// held query in the cycle it is accepted; the lane sums are registered in the
// front stage, added by the merge stage and registered again as a tracker item,
// and the tracker then updates the best two. A result is registered in the
// tracker's output register once the last candidate of a run reaches it and
// waits there until taken, while non-emitting words keep flowing behind it. The
// distance_mode register (byte address 0) selects Hamming (0) or squared L2 over
// bytes (1); change it only while idle.
`include "descriptor_best_two_matcher_defines.svh"

module descriptor_best_two_matcher
  import dbtm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_command,
  input  logic [WORD_W-1:0]     in_desc_word_0,
  input  logic [WORD_W-1:0]     in_desc_word_1,
  input  logic [WORD_W-1:0]     in_desc_word_2,
  input  logic [WORD_W-1:0]     in_desc_word_3,
  input  logic [PORT_IDX_W-1:0] in_item_index,
  input  logic                  in_last,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PORT_IDX_W-1:0] out_query_index,
  output logic [PORT_IDX_W-1:0] out_best_index,
  output logic [DIST_W-1:0]     out_best_distance,
  output logic [PORT_IDX_W-1:0] out_second_index,
  output logic [DIST_W-1:0]     out_second_distance,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [WORD_W-1:0] in_word [NUM_WORDS];
  logic [WORD_W-1:0] query_r [NUM_LANES];
  logic              distance_mode_r;
  logic              cfg_we;
  logic              in_fire;

  logic [LANE_W-1:0] lane_part [NUM_LANES];
  logic [LANE_W-1:0] s1_part_r [NUM_LANES];
  logic              s1_valid_r;
  logic              s1_cmd_r;
  logic              s1_last_r;
  logic [IDX_W-1:0]  s1_idx_r;
  logic [DIST_W-1:0] merged_dist;

  logic              s2_valid_r;
  dbtm_item_t        s2_item_r;
  logic              s2_take;
  logic              s2_free;
  logic              s1_free;
  dbtm_result_t      result;

  assign in_word[0] = in_desc_word_0;
  assign in_word[1] = in_desc_word_1;
  assign in_word[2] = in_desc_word_2;
  assign in_word[3] = in_desc_word_3;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_DISTANCE_MODE) ?
                  CFG_DATA_W'(distance_mode_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      distance_mode_r <= MODE_HAMMING;
    end else if (cfg_we && (paddr[2] == REG_DISTANCE_MODE)) begin
      distance_mode_r <= pwdata[0];
    end
  end

  // Pipeline flow control: a stage moves on when the stage after it has room.
  assign s2_free  = !s2_valid_r || s2_take;
  assign s1_free  = !s1_valid_r || s2_free;
  assign in_ready = s1_free;
  assign in_fire  = in_valid && in_ready;

  // The query is loaded on acceptance, so a candidate right behind a start
  // already meets the new descriptor in the lanes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        query_r[l] <= '0;
      end
    end else if (in_fire && (in_command == CMD_START)) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        query_r[l] <= in_word[l];
      end
    end
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    dbtm_lane u_lane (
      .mode       (distance_mode_r),
      .query_word (query_r[l]),
      .cand_word  (in_word[l]),
      .byte_mask  (lane_mask(l)),
      .partial    (lane_part[l])
    );
  end

  dbtm_merge u_merge (
    .partial (s1_part_r),
    .total   (merged_dist)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_r <= in_fire;
      end
      if (s2_free) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_part_r <= lane_part;
      s1_cmd_r  <= in_command;
      s1_last_r <= in_last;
      s1_idx_r  <= IDX_W'(in_item_index);
    end
    if (s2_free && s1_valid_r) begin
      s2_item_r <= '{cmd: s1_cmd_r, last: s1_last_r, idx: s1_idx_r, distance: merged_dist};
    end
  end

  dbtm_tracker u_tracker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (s2_item_r),
    .item_valid (s2_valid_r),
    .item_take  (s2_take),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .result     (result)
  );

  assign out_query_index     = result.query_index;
  assign out_best_index      = result.best_index;
  assign out_best_distance   = result.best_distance;
  assign out_second_index    = result.second_index;
  assign out_second_distance = result.second_distance;

  `DBTM_ASSERT_ALWAYS(a_out_idle_after_reset, !rst_n |=> !out_valid, "result after reset")
  `DBTM_ASSERT(a_best_not_worse, out_valid |-> (out_best_distance <= out_second_distance), "best worse than second")
  `DBTM_ASSERT(a_ready_when_empty, !s1_valid_r |-> in_ready, "input stalled with empty front stage")
  `DBTM_ASSERT(a_result_from_last, $rose(out_valid) |-> $past(s2_valid_r && s2_item_r.cmd && s2_item_r.last), "result without last candidate")

endmodule

// ===== tb/sv/tb_descriptor_best_two_matcher.sv =====
// Self-checking testbench for descriptor_best_two_matcher: drives start and candidate words,
// predicts the best-two matches in both distance modes and checks every result word.
// Depends on dbtm_pkg and the descriptor_best_two_matcher RTL only.
module tb_descriptor_best_two_matcher;
  timeunit 1ns;
  timeprecision 1ps;
  import dbtm_pkg::*;

  typedef struct packed {
    logic         cmd;
    logic [255:0] desc;
    logic [15:0]  idx;
    logic         last;
  } desc_word_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_command = CMD_START;
  logic [WORD_W-1:0]     in_desc_word_0 = '0;
  logic [WORD_W-1:0]     in_desc_word_1 = '0;
  logic [WORD_W-1:0]     in_desc_word_2 = '0;
  logic [WORD_W-1:0]     in_desc_word_3 = '0;
  logic [PORT_IDX_W-1:0] in_item_index = '0;
  logic                  in_last = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PORT_IDX_W-1:0] out_query_index;
  logic [PORT_IDX_W-1:0] out_best_index;
  logic [DIST_W-1:0]     out_best_distance;
  logic [PORT_IDX_W-1:0] out_second_index;
  logic [DIST_W-1:0]     out_second_distance;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Predictor state: held query, run length (saturates at two) and the best two so far.
  logic         l2_mode = MODE_HAMMING;
  logic [255:0] held_query = '0;
  logic [15:0]  held_query_index = '0;
  int           run_len = 0;
  logic [21:0]  lead_dist = '0;
  logic [15:0]  best_idx = '0;
  logic [21:0]  runner_dist = '0;
  logic [15:0]  runner_idx = '0;

  dbtm_result_t pending_matches[$];
  desc_word_t   word_queue[$];
  desc_word_t   word_on_bus;
  int           words_queued = 0;
  int           words_sent = 0;
  int           l2_words = 0;
  int           results_seen = 0;
  int           mismatches = 0;
  int           tx_gap = 0;
  int           rx_gap = 0;
  int           phase_no = -1;
  logic         quiet = 1'b0;
  logic         long_hold = 1'b0;

  descriptor_best_two_matcher u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_desc_word_0      (in_desc_word_0),
    .in_desc_word_1      (in_desc_word_1),
    .in_desc_word_2      (in_desc_word_2),
    .in_desc_word_3      (in_desc_word_3),
    .in_item_index       (in_item_index),
    .in_last             (in_last),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_query_index     (out_query_index),
    .out_best_index      (out_best_index),
    .out_best_distance   (out_best_distance),
    .out_second_index    (out_second_index),
    .out_second_distance (out_second_distance),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [21:0] descriptor_distance(input logic [255:0] a,
                                                      input logic [255:0] b,
                                                      input logic use_l2);
    int unsigned acc;
    int          diff;
    acc = 0;
    for (int k = 0; k < DESC_BYTES; k++) begin
      if (use_l2 == MODE_L2) begin
        diff = int'(a[8*k +: 8]) - int'(b[8*k +: 8]);
        acc += diff * diff;
      end else begin
        acc += $countones(a[8*k +: 8] ^ b[8*k +: 8]);
      end
    end
    return 22'(acc);
  endfunction

  function automatic void track_best_two(input desc_word_t w);
    logic [21:0]  d;
    dbtm_result_t m;
    if (w.cmd == CMD_START) begin
      held_query       = w.desc;
      held_query_index = w.idx;
      run_len          = 0;
      return;
    end
    d = descriptor_distance(held_query, w.desc, l2_mode);
    if (run_len == 0) begin
      lead_dist = d;
      best_idx  = w.idx;
      run_len   = 1;
    end else if (run_len == 1) begin
      // On a tie between the first two candidates the newer one ranks best.
      if (lead_dist < d) begin
        runner_dist = d;
        runner_idx  = w.idx;
      end else begin
        runner_dist = lead_dist;
        runner_idx  = best_idx;
        lead_dist   = d;
        best_idx    = w.idx;
      end
      run_len = 2;
    end else if (d < lead_dist) begin
      runner_dist = lead_dist;
      runner_idx  = best_idx;
      lead_dist   = d;
      best_idx    = w.idx;
    end else if (d < runner_dist) begin
      runner_dist = d;
      runner_idx  = w.idx;
    end
    if (w.last) begin
      if (run_len == 2) begin
        m.query_index     = held_query_index;
        m.best_index      = best_idx;
        m.best_distance   = lead_dist[DIST_W-1:0];
        m.second_index    = runner_idx;
        m.second_distance = runner_dist[DIST_W-1:0];
        pending_matches = {pending_matches, m};
      end
      run_len = 0;
    end
  endfunction

  function automatic void note_mismatch(input string what, input dbtm_result_t e,
                                        input dbtm_result_t a);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected q=%0d best=%0d/%0d second=%0d/%0d", $realtime, what,
               e.query_index, e.best_index, e.best_distance, e.second_index,
               e.second_distance);
      $display("%0t: %s:   actual q=%0d best=%0d/%0d second=%0d/%0d", $realtime, what,
               a.query_index, a.best_index, a.best_distance, a.second_index,
               a.second_distance);
    end
  endfunction

  // Word driver: valid is held with a stable payload until the word is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        track_best_two(word_on_bus);
        if (l2_mode == MODE_L2) l2_words++;
        words_sent++;
      end
      if (!in_valid || in_ready) begin
        if (tx_gap != 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (word_queue.size() != 0 && !quiet && $urandom_range(0, 9) == 0) begin
          tx_gap = $urandom_range(0, 4);
          in_valid <= 1'b0;
        end else if (word_queue.size() != 0) begin
          word_on_bus = word_queue.pop_front();
          in_valid       <= 1'b1;
          in_command     <= word_on_bus.cmd;
          in_desc_word_0 <= word_on_bus.desc[63:0];
          in_desc_word_1 <= word_on_bus.desc[127:64];
          in_desc_word_2 <= word_on_bus.desc[191:128];
          in_desc_word_3 <= word_on_bus.desc[255:192];
          in_item_index  <= word_on_bus.idx;
          in_last        <= word_on_bus.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure.
  always @(posedge clk) begin
    dbtm_result_t act;
    dbtm_result_t exp;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        act.query_index     = out_query_index;
        act.best_index      = out_best_index;
        act.best_distance   = out_best_distance;
        act.second_index    = out_second_index;
        act.second_distance = out_second_distance;
        results_seen++;
        if (pending_matches.size() == 0) begin
          note_mismatch("result with none expected", '0, act);
        end else begin
          exp = pending_matches.pop_front();
          if (act.query_index !== exp.query_index || act.best_index !== exp.best_index ||
              act.best_distance !== exp.best_distance ||
              act.second_index !== exp.second_index ||
              act.second_distance !== exp.second_distance) begin
            note_mismatch("result mismatch", exp, act);
          end
        end
      end
      if (rx_gap != 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        rx_gap = $urandom_range(0, 4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= !long_hold;
      end
    end
  end

  // A long receiver hold-off so that the output backs up and the input stalls.
  initial begin
    wait (phase_no == 2);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (400) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin
    #10ms;
    $display("descriptor_best_two_matcher test failed");
    $finish;
  end

  task automatic reg_write(input int unsigned addr, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(addr);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if ((addr >> 2) == REG_DISTANCE_MODE) l2_mode = data[0];
  endtask

  task automatic reg_read_check(input int unsigned addr);
    logic [CFG_DATA_W-1:0] want;
    want = {{(CFG_DATA_W-1){1'b0}}, l2_mode};
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CFG_ADDR_W'(addr);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: register read at %0d: expected %0h, actual %0h", $realtime, addr,
                 want, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic queue_word(input logic cmd, input logic [255:0] desc, input logic [15:0] idx,
                            input logic last);
    desc_word_t w;
    w.cmd  = cmd;
    w.desc = desc;
    w.idx  = idx;
    w.last = last;
    word_queue = {word_queue, w};
    words_queued++;
  endtask

  // Wait until every word is taken and every result has come, then let the pipeline empty.
  task automatic drain();
    while (words_sent != words_queued || pending_matches.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [255:0] random_desc();
    logic [255:0] r;
    for (int k = 0; k < 8; k++) r[32*k +: 32] = $urandom;
    return r;
  endfunction

  function automatic logic [15:0] random_index();
    case ($urandom_range(0, 19))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Candidates close to the query give small, often tied distances.
  function automatic logic [255:0] variant_of(input logic [255:0] base);
    logic [255:0] v;
    int           k;
    v = base;
    case ($urandom_range(0, 9))
      0, 1: ;
      2, 3, 4: repeat ($urandom_range(1, 6)) v[$urandom_range(0, 255)] ^= 1'b1;
      5, 6: repeat ($urandom_range(1, 8)) begin
        k = $urandom_range(0, 31);
        v[8*k +: 8] = v[8*k +: 8] + 8'($urandom_range(0, 6)) - 8'd3;
      end
      7: v = random_desc();
      8: v = ($urandom_range(0, 1) != 0) ? '1 : '0;
      default: v = ~base;
    endcase
    return v;
  endfunction

  task automatic queue_run();
    int           kind;
    int           n;
    logic         ends_run;
    logic [255:0] q;
    logic [255:0] pool[3];
    logic [255:0] c;
    kind = $urandom_range(0, 99);
    q = ($urandom_range(0, 15) == 0) ? (($urandom_range(0, 1) != 0) ? '1 : '0) : random_desc();
    for (int j = 0; j < 3; j++) pool[j] = variant_of(q);
    ends_run = 1'b1;
    if (kind < 80) begin
      n = $urandom_range(2, 7);
    end else if (kind < 88) begin
      n = $urandom_range(0, 1);
    end else if (kind < 94) begin
      n = $urandom_range(1, 3);
      ends_run = 1'b0;
    end else begin
      n = $urandom_range(1, 4);
    end
    // The last kind continues against whatever query the block already holds.
    if (kind < 94) queue_word(CMD_START, q, random_index(), $urandom_range(0, 9) == 0);
    for (int i = 0; i < n; i++) begin
      c = ($urandom_range(0, 4) < 2) ? pool[$urandom_range(0, 2)] : variant_of(q);
      queue_word(CMD_CANDIDATE, c, random_index(), ends_run && (i == n - 1));
    end
  endtask

  initial begin
    logic [255:0] qd;
    int           phase_start;
    logic         phase_mode[6];
    qd = 256'h0123456789abcdef_fedcba9876543210_00ff00ff55aa55aa_0f0f0f0ff0f0f0f0;
    phase_mode = '{MODE_HAMMING, MODE_L2, MODE_L2, MODE_HAMMING, MODE_L2, MODE_HAMMING};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset value, then a write to a register that does not exist.
    reg_read_check(0);
    reg_write(4, 32'h1);
    reg_read_check(0);

    // Hamming mode: candidates before any start, single-candidate run, ties, back-to-back
    // starts, a start carrying last, extreme indexes.
    queue_word(CMD_CANDIDATE, '1, 16'd5, 1'b0);
    queue_word(CMD_CANDIDATE, '0, 16'd6, 1'b1);
    queue_word(CMD_START, qd, 16'hFFFF, 1'b1);
    queue_word(CMD_CANDIDATE, qd ^ 256'h1, 16'd1, 1'b1);
    queue_word(CMD_CANDIDATE, qd, 16'd2, 1'b0);
    queue_word(CMD_CANDIDATE, qd, 16'd3, 1'b0);
    queue_word(CMD_CANDIDATE, qd, 16'd4, 1'b0);
    queue_word(CMD_CANDIDATE, ~qd, 16'd0, 1'b1);
    queue_word(CMD_START, random_desc(), 16'd0, 1'b0);
    queue_word(CMD_START, qd, 16'd7, 1'b0);
    queue_word(CMD_CANDIDATE, qd ^ 256'h1, 16'hFFFF, 1'b0);
    queue_word(CMD_CANDIDATE, qd ^ 256'h3, 16'd0, 1'b0);
    queue_word(CMD_CANDIDATE, qd ^ (256'h1 << 255), 16'd9, 1'b0);
    queue_word(CMD_CANDIDATE, qd ^ (256'h3 << 100), 16'd10, 1'b1);
    drain();

    // Squared L2: the largest possible distance and byte-level ties.
    reg_write(0, 32'h1);
    reg_read_check(0);
    queue_word(CMD_START, '0, 16'h1234, 1'b0);
    queue_word(CMD_CANDIDATE, '1, 16'hFFFF, 1'b0);
    queue_word(CMD_CANDIDATE, {32{8'h01}}, 16'd0, 1'b0);
    queue_word(CMD_CANDIDATE, {32{8'h80}}, 16'd2, 1'b0);
    queue_word(CMD_CANDIDATE, {32{8'h01}}, 16'd3, 1'b1);
    queue_word(CMD_START, qd, 16'd0, 1'b0);
    queue_word(CMD_CANDIDATE, qd, 16'd5, 1'b0);
    queue_word(CMD_CANDIDATE, qd ^ 256'hff, 16'd6, 1'b1);
    drain();

    for (int p = 0; p < 6; p++) begin
      phase_no = p;
      quiet = (p == 5);
      reg_write(0, {31'b0, phase_mode[p]});
      reg_read_check(0);
      phase_start = words_queued;
      while (words_queued - phase_start < 240) queue_run();
      drain();
    end

    mismatches += pending_matches.size();
    $display("Ran %0d words (%0d with squared L2 distance, the rest Hamming) and checked %0d",
             words_sent, l2_words, results_seen);
    $display("best-two results, with register writes, ties, short runs and output stalls.");
    if (mismatches == 0) begin
      $display("descriptor_best_two_matcher test passed");
    end else begin
      $display("descriptor_best_two_matcher test failed");
    end
    $finish;
  end

endmodule
